// ----- rtl/core/stepper_step_dir_pulse_generator_top_macros.svh -----
// Assertion macros used by the step/dir pulse generator core (stp_core)
`ifndef STEPPER_STEP_DIR_PULSE_GENERATOR_TOP_MACROS_SVH
`define STEPPER_STEP_DIR_PULSE_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define STP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define STP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/stp_pkg.sv -----
// Types and constants of the step/dir pulse generator
package stp_pkg;

  localparam int PERIOD_W = 23;
  localparam int COUNT_W  = 31;
  localparam int STEPS_W  = 32;
  localparam int KIND_W   = 2;
  localparam int PCNT_W   = 16;
  localparam int PSC_W    = 7;

  localparam int PRESCALE     = 100;
  localparam int RESET_PERIOD = 1000;

  localparam int DEF_MIN_PERIOD  = 10;
  localparam int DEF_MAX_PERIOD  = 6553600;
  localparam int DEF_TIMER_LIMIT = 65535;
  localparam int DEF_PULSE_LEN   = 10;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_STOP = 2'd2
  } kind_t;

  typedef struct packed {
    logic              coarse;
    logic [PCNT_W-1:0] reload;
  } timer_cfg_t;

  typedef struct packed {
    logic                step_pin;
    logic                dir_pin;
    logic                moving;
    logic [COUNT_W-1:0]  remaining;
    logic                step_taken;
    logic [PERIOD_W-1:0] period_in_use;
  } result_t;

endpackage

// ----- rtl/core/stp_cfg.sv -----
// Period register and derivation of timer divider and reload
module stp_cfg import stp_pkg::*; #(
  parameter int MIN_PERIOD  = DEF_MIN_PERIOD,
  parameter int MAX_PERIOD  = DEF_MAX_PERIOD,
  parameter int TIMER_LIMIT = DEF_TIMER_LIMIT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data,
  output logic                pend,
  output timer_cfg_t          tcfg
);

  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam int PROD_W      = PERIOD_W + RECIP_W;
  localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + PRESCALE - 1) / PRESCALE;
  localparam bit RST_LARGE   = RESET_PERIOD > TIMER_LIMIT;
  localparam int RST_RELOAD  = (RST_LARGE ? RESET_PERIOD / PRESCALE : RESET_PERIOD) - 1;

  logic [PERIOD_W-1:0] period;
  logic [PROD_W-1:0]   prod;
  logic [PCNT_W-1:0]   quot;
  logic                wr_ok;
  logic                large_next;

  assign cfg_ready  = !pend;
  assign wr_ok      = cfg_valid && cfg_ready &&
                      (cfg_data > PERIOD_W'(MIN_PERIOD)) &&
                      (cfg_data < PERIOD_W'(MAX_PERIOD));
  assign prod       = PROD_W'(period) * PROD_W'(RECIP);
  assign quot       = prod[RECIP_SHIFT +: PCNT_W];
  assign large_next = period > PERIOD_W'(TIMER_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      period      <= PERIOD_W'(RESET_PERIOD);
      pend        <= 1'b0;
      tcfg.coarse <= RST_LARGE;
      tcfg.reload <= PCNT_W'(RST_RELOAD);
    end else begin
      pend <= wr_ok;
      if (wr_ok) begin
        period <= cfg_data;
      end
      if (pend) begin
        tcfg.coarse <= large_next;
        tcfg.reload <= large_next ? quot - 1'b1 : period[PCNT_W-1:0] - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/stp_core.sv -----
// Step timer, step counter and direction state with result formation
module stp_core import stp_pkg::*; #(
  parameter int PULSE_LEN = DEF_PULSE_LEN
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [KIND_W-1:0]  kind,
  input  logic [STEPS_W-1:0] steps,
  input  timer_cfg_t         tcfg,
  output result_t            result
);

  `include "stepper_step_dir_pulse_generator_top_macros.svh"

  logic [COUNT_W-1:0] remaining_count, remaining_count_next;
  logic               direction, direction_next;
  logic               running, running_next;
  logic [PCNT_W-1:0]  period_counter, period_counter_next;
  logic [PSC_W-1:0]   prescale_counter, prescale_counter_next;
  logic               taken;

  logic [PSC_W-1:0]   psc_inc;
  logic [PSC_W-1:0]   divider;
  logic [COUNT_W-1:0] rem_base;
  logic               dir_base;
  logic [COUNT_W+1:0] sum;
  logic [COUNT_W+1:0] mag;
  logic               neg;
  logic [COUNT_W-1:0] rem_new;
  logic [PCNT_W:0]    reload_inc;

  assign psc_inc    = prescale_counter + 1'b1;
  assign divider    = tcfg.coarse ? PSC_W'(PRESCALE) : PSC_W'(1);
  assign rem_base   = running ? remaining_count : '0;
  assign dir_base   = running ? direction : 1'b1;
  assign sum        = {2'b00, rem_base} + {steps[STEPS_W-1], steps};
  assign neg        = sum[COUNT_W+1];
  assign mag        = neg ? -sum : sum;
  assign rem_new    = (mag[COUNT_W+1:COUNT_W] != 2'b00) ? '1 : mag[COUNT_W-1:0];
  assign reload_inc = {1'b0, tcfg.reload} + 1'b1;

  always_comb begin
    remaining_count_next  = remaining_count;
    direction_next        = direction;
    running_next          = running;
    period_counter_next   = period_counter;
    prescale_counter_next = prescale_counter;
    taken                 = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (running) begin
          prescale_counter_next = psc_inc;
          if (psc_inc >= divider) begin
            prescale_counter_next = '0;
            if (period_counter >= tcfg.reload) begin
              period_counter_next = '0;
              taken               = 1'b1;
              if (remaining_count <= COUNT_W'(1)) begin
                running_next         = 1'b0;
                remaining_count_next = '0;
                direction_next       = 1'b1;
              end else begin
                remaining_count_next = remaining_count - 1'b1;
              end
            end else begin
              period_counter_next = period_counter + 1'b1;
            end
          end
        end
      end
      KIND_MOVE: begin
        if (steps != '0) begin
          remaining_count_next = rem_new;
          direction_next       = dir_base ^ neg;
          if (!running) begin
            period_counter_next   = '0;
            prescale_counter_next = '0;
            running_next          = 1'b1;
          end
        end
      end
      KIND_STOP: begin
        running_next         = 1'b0;
        remaining_count_next = '0;
        direction_next       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.step_pin      = !(running_next && (period_counter_next < PCNT_W'(PULSE_LEN)));
    result.dir_pin       = direction_next;
    result.moving        = running_next;
    result.remaining     = remaining_count_next;
    result.step_taken    = taken;
    result.period_in_use = tcfg.coarse ?
                           PERIOD_W'(PERIOD_W'(reload_inc) * PERIOD_W'(PRESCALE)) :
                           PERIOD_W'(reload_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_count  <= '0;
      direction        <= 1'b1;
      running          <= 1'b0;
      period_counter   <= '0;
      prescale_counter <= '0;
    end else if (accept) begin
      remaining_count  <= remaining_count_next;
      direction        <= direction_next;
      running          <= running_next;
      period_counter   <= period_counter_next;
      prescale_counter <= prescale_counter_next;
    end
  end

  `STP_ASSERT_IMPL(a_idle_clear, clk, rst, !running,
                   (remaining_count == '0) && direction, "idle with steps or reversed")
  `STP_ASSERT_IMPL(a_psc_range, clk, rst, 1'b1,
                   prescale_counter < PSC_W'(PRESCALE), "prescaler past divider")
  `STP_ASSERT_NEXT(a_stop, clk, rst, accept && (kind == KIND_STOP),
                   !running, "still running after stop")
  `STP_ASSERT_NEXT(a_fast_psc, clk, rst,
                   accept && running && !tcfg.coarse && (kind == KIND_TICK),
                   prescale_counter == '0, "prescaler moved at divider one")

endmodule

// ----- rtl/core/stp_obuf.sv -----
// Two-word output queue between the step logic and the result channel
module stp_obuf import stp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t dout
);

  logic [1:0] count;
  result_t    head;
  result_t    tail;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = count != 2'd0;
  assign full      = count == 2'd2;
  assign dout      = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          head <= din;
        end else begin
          tail <= din;
        end
      end
      2'b01: head <= tail;
      2'b11: begin
        if (count == 2'd1) begin
          head <= din;
        end else begin
          head <= tail;
          tail <= din;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/stepper_step_dir_pulse_generator_top.sv -----
// Step/dir pulse generator: one word in per cycle while in_stall is low, one result word out
// per word. Every input word (base tick, signed move, stop) is applied to the timer and step
// state in the cycle it is taken and its result enters a registered two-word output queue,
// which offers it once the words ahead of it have been taken. in_stall rises only while
// that queue is full, and while an accepted period write is pending and the reciprocal
// multiplier derives the timer reload; cfg_ready is low while that write is pending.
module stepper_step_dir_pulse_generator_top import stp_pkg::*; #(
  parameter int MIN_PERIOD  = DEF_MIN_PERIOD,
  parameter int MAX_PERIOD  = DEF_MAX_PERIOD,
  parameter int TIMER_LIMIT = DEF_TIMER_LIMIT,
  parameter int PULSE_LEN   = DEF_PULSE_LEN
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [STEPS_W-1:0]  steps,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                step_pin,
  output logic                dir_pin,
  output logic                moving,
  output logic [COUNT_W-1:0]  remaining,
  output logic                step_taken,
  output logic [PERIOD_W-1:0] period_in_use,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data
);

  timer_cfg_t tcfg;
  result_t    result;
  result_t    dout;
  logic       pend;
  logic       full;
  logic       accept;

  assign in_stall = pend || full;
  assign accept   = in_valid && !in_stall;

  stp_cfg #(
    .MIN_PERIOD  (MIN_PERIOD),
    .MAX_PERIOD  (MAX_PERIOD),
    .TIMER_LIMIT (TIMER_LIMIT)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pend      (pend),
    .tcfg      (tcfg)
  );

  stp_core #(
    .PULSE_LEN (PULSE_LEN)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (kind),
    .steps  (steps),
    .tcfg   (tcfg),
    .result (result)
  );

  stp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .din       (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (dout)
  );

  assign step_pin      = dout.step_pin;
  assign dir_pin       = dout.dir_pin;
  assign moving        = dout.moving;
  assign remaining     = dout.remaining;
  assign step_taken    = dout.step_taken;
  assign period_in_use = dout.period_in_use;

endmodule

// ----- bench/stepper_step_dir_pulse_generator_scoreboard.sv -----
// Scoreboard for the step/dir pulse generator: predicts each result word and compares it
module stepper_step_dir_pulse_generator_scoreboard import stp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [STEPS_W-1:0]  steps,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                step_pin,
  input  logic                dir_pin,
  input  logic                moving,
  input  logic [COUNT_W-1:0]  remaining,
  input  logic                step_taken,
  input  logic [PERIOD_W-1:0] period_in_use,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint COUNT_MAX = 64'd2147483647;

  logic [PERIOD_W-1:0] tgt_period;
  longint              cnt_left;
  logic                dir_q;
  logic                run_q;
  int                  per_cnt;
  int                  psc_cnt;
  result_t             motor_results_q[$];

  function automatic int timer_div();
    return (tgt_period > DEF_TIMER_LIMIT) ? PRESCALE : 1;
  endfunction

  function automatic int timer_reload();
    int p;
    p = (tgt_period > DEF_TIMER_LIMIT) ? int'(tgt_period) / PRESCALE : int'(tgt_period);
    return (p - 1) & 16'hFFFF;
  endfunction

  task automatic park_motor();
    run_q    = 1'b0;
    cnt_left = 0;
    dir_q    = 1'b1;
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 40) $display("mismatch on %s: got %0d, want %0d", what, got, want);
  endtask

  task automatic advance_motor(input logic [KIND_W-1:0] k, input logic [STEPS_W-1:0] s);
    longint  n;
    longint  sum;
    logic    took;
    result_t r;
    n    = longint'($signed(s));
    took = 1'b0;
    case (k)
      KIND_TICK: begin
        if (run_q) begin
          psc_cnt++;
          if (psc_cnt >= timer_div()) begin
            psc_cnt = 0;
            if (per_cnt >= timer_reload()) begin
              per_cnt = 0;
              took    = 1'b1;
              if (cnt_left <= 1) park_motor();
              else cnt_left--;
            end else begin
              per_cnt++;
            end
          end
        end
      end
      KIND_MOVE: begin
        if (n != 0) begin
          if (run_q) begin
            sum = cnt_left + n;
            if (sum < 0) begin
              sum   = -sum;
              dir_q = ~dir_q;
            end
            cnt_left = (sum > COUNT_MAX) ? COUNT_MAX : sum;
          end else begin
            dir_q = 1'b1;
            if (n < 0) begin
              dir_q = 1'b0;
              n     = -n;
            end
            cnt_left = (n > COUNT_MAX) ? COUNT_MAX : n;
            per_cnt  = 0;
            psc_cnt  = 0;
            run_q    = 1'b1;
          end
        end
      end
      KIND_STOP: park_motor();
      default: ;
    endcase
    r.step_pin      = (run_q && per_cnt < DEF_PULSE_LEN) ? 1'b0 : 1'b1;
    r.dir_pin       = dir_q;
    r.moving        = run_q;
    r.remaining     = COUNT_W'(cnt_left);
    r.step_taken    = took;
    r.period_in_use = PERIOD_W'((timer_reload() + 1) * timer_div());
    motor_results_q.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      tgt_period = PERIOD_W'(RESET_PERIOD);
      per_cnt    = 0;
      psc_cnt    = 0;
      park_motor();
      motor_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_data > DEF_MIN_PERIOD && cfg_data < DEF_MAX_PERIOD)
        tgt_period = cfg_data;
      if (in_valid && !in_stall) advance_motor(kind, steps);
      if (out_valid && !out_stall) begin
        if (motor_results_q.size() == 0) begin
          flag_mismatch("unexpected word", 1, 0);
        end else begin
          want = motor_results_q.pop_front();
          if (step_pin !== want.step_pin) flag_mismatch("step_pin", step_pin, want.step_pin);
          if (dir_pin !== want.dir_pin) flag_mismatch("dir_pin", dir_pin, want.dir_pin);
          if (moving !== want.moving) flag_mismatch("moving", moving, want.moving);
          if (remaining !== want.remaining)
            flag_mismatch("remaining", remaining, want.remaining);
          if (step_taken !== want.step_taken)
            flag_mismatch("step_taken", step_taken, want.step_taken);
          if (period_in_use !== want.period_in_use)
            flag_mismatch("period_in_use", period_in_use, want.period_in_use);
        end
      end
    end
    pending <= motor_results_q.size();
  end

endmodule

// ----- bench/stepper_step_dir_pulse_generator_top_tb.sv -----
// Testbench top for the step/dir pulse generator: stimulus, flow control and verdict
module stepper_step_dir_pulse_generator_top_tb;
  import stp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int STALL_LIMIT  = 4000;
  localparam int SQUEEZE_LEN  = 400;
  localparam int N_PHASES     = 12;
  localparam int PHASE_ITEMS  = 115;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   kind = KIND_TICK;
  logic [STEPS_W-1:0]  steps = '0;
  logic                out_valid;
  logic                out_stall = 1'b1;
  logic                step_pin;
  logic                dir_pin;
  logic                moving;
  logic [COUNT_W-1:0]  remaining;
  logic                step_taken;
  logic [PERIOD_W-1:0] period_in_use;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data = '0;
  logic                calm = 1'b0;
  logic                squeeze_go = 1'b0;
  logic                rx_hold = 1'b0;
  int                  errors;
  int                  pending;
  int                  idle_cycles = 0;

  always #10 clk = ~clk;

  stepper_step_dir_pulse_generator_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .steps         (steps),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .step_pin      (step_pin),
    .dir_pin       (dir_pin),
    .moving        (moving),
    .remaining     (remaining),
    .step_taken    (step_taken),
    .period_in_use (period_in_use),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  stepper_step_dir_pulse_generator_scoreboard u_score (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .steps         (steps),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .step_pin      (step_pin),
    .dir_pin       (dir_pin),
    .moving        (moving),
    .remaining     (remaining),
    .step_taken    (step_taken),
    .period_in_use (period_in_use),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending)
  );

  // hold the receiver off for a long stretch once
  initial begin
    wait (squeeze_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (SQUEEZE_LEN) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) gap = calm ? 0 : $urandom_range(0, 11);
      if (rx_hold || gap > 0) begin
        out_stall <= 1'b1;
        if (gap > 0) gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("stepper_step_dir_pulse_generator_top test failed");
      $finish;
    end
  end

  task automatic push_word(input logic [KIND_W-1:0] k, input logic [STEPS_W-1:0] s);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    steps    <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_period(input logic [PERIOD_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [PERIOD_W-1:0] phase_period [N_PHASES];
    int pick;
    phase_period = '{23'd17, 23'h7FFFFF, 23'd65535, 23'd25, 23'd65536, 23'd12,
                     23'd6553599, 23'd0, 23'd1000, 23'd11, 23'd6553600, 23'd40};
    phase_period[8] = PERIOD_W'($urandom);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // idle words at the reset period, rejected and accepted period writes, then moves and ticks
    push_word(KIND_TICK, 32'hFFFFFFFF);
    push_word(KIND_STOP, 32'h0);
    push_word(KIND_SPARE, $urandom);
    push_word(KIND_MOVE, 32'h0);
    set_period(23'd10);
    set_period(23'd6553600);
    set_period(23'd11);
    push_word(KIND_MOVE, 32'd3);
    repeat (11) push_word(KIND_TICK, $urandom);
    push_word(KIND_MOVE, -32'sd5);
    push_word(KIND_MOVE, 32'h7FFFFFFF);
    push_word(KIND_MOVE, 32'h80000001);
    push_word(KIND_STOP, $urandom);
    push_word(KIND_MOVE, 32'h80000000);
    push_word(KIND_MOVE, 32'h80000000);
    push_word(KIND_SPARE, $urandom);
    push_word(KIND_TICK, $urandom);
    push_word(KIND_STOP, $urandom);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_period(phase_period[ph]);
      calm <= (ph % 3 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 20) squeeze_go <= 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 78) push_word(KIND_TICK, $urandom);
        else if (pick < 90) push_word(KIND_MOVE, int'($urandom_range(0, 12)) - 6);
        else if (pick < 94) push_word(KIND_MOVE, $urandom);
        else if (pick < 98) push_word(KIND_STOP, $urandom);
        else push_word(KIND_SPARE, $urandom);
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("stepper_step_dir_pulse_generator_top test passed");
    else
      $display("stepper_step_dir_pulse_generator_top test failed");
    $finish;
  end

endmodule
